### hw/rtl/pss_pkg.sv
// Shared types and constants for the polynomial sag and slope evaluator.
package pss_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned TERM_W    = DATA_W + IDX_W + 1;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned ADDR_W    = 3;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  localparam logic REG_FIRST = 1'b0;
  localparam logic REG_LAST  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef enum logic {
    CH_SAG,
    CH_SLOPE
  } chain_e;

  typedef struct packed {
    logic   vld;
    chain_e chain;
  } mac_req_t;

  typedef struct packed {
    logic                     vld;
    chain_e                   chain;
    logic                     sat;
    logic signed [DATA_W-1:0] res;
  } mac_rsp_t;

endpackage

### hw/rtl/polynomial_sag_and_slope.sv
// Polynomial sag and slope evaluator, Horner's rule on one shared multiplier.
// Evaluate: Horner steps run from L, the highest configured term, down to power zero;
// each term issues a sag then a slope product, power zero only the sag product.
// Coefficient write: the result is all zero. No new item is taken until the last result loads.
// A result held by the receiver stalls the next item until that result transfers.
// Reset clears the coefficient table, the term range registers and all control state.
module polynomial_sag_and_slope #(
  parameter int unsigned TERM_COUNT = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [pss_pkg::ADDR_W-1:0]   paddr,
  input  logic        [31:0]                  pwdata,
  output logic        [31:0]                  prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic        [pss_pkg::IDX_W-1:0]    term_index_i,
  input  logic signed [pss_pkg::DATA_W-1:0]   coeff_value_i,
  input  logic signed [pss_pkg::DATA_W-1:0]   radius_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pss_pkg::DATA_W-1:0]   sag_value_o,
  output logic signed [pss_pkg::DATA_W-1:0]   slope_value_o,
  output logic                                overflow_o
);

  localparam int unsigned IW = pss_pkg::IDX_W;
  localparam int unsigned DW = pss_pkg::DATA_W;
  localparam int unsigned TW = pss_pkg::TERM_W;
  localparam int unsigned TABLE_DEPTH = (TERM_COUNT < (1 << IW)) ? TERM_COUNT : (1 << IW);

  pss_pkg::state_e state_q, state_d;
  logic            ph_q, ph_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   first_q, last_q;
  logic signed [DW-1:0] r_q, r_d;
  logic signed [DW-1:0] y_sag_q, y_sag_d, y_slp_q, y_slp_d;
  logic            ov_q, ov_d;

  logic                 out_valid_q;
  logic signed [DW-1:0] sag_out_q, slp_out_q;
  logic                 ov_out_q;
  logic                 out_load;

  logic                 table_we;
  logic signed [DW-1:0] coef;
  logic [IW-1:0]        slope_start;
  logic signed [IW:0]   idx_s;
  logic signed [TW-1:0] sag_term, slp_term;

  pss_pkg::mac_req_t    mac_req;
  pss_pkg::mac_rsp_t    mac_rsp;
  logic signed [DW-1:0] mac_a;
  logic signed [TW-1:0] mac_term;
  logic                 cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      last_q  <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        pss_pkg::REG_FIRST: first_q <= pwdata[IW-1:0];
        pss_pkg::REG_LAST:  last_q  <= pwdata[IW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pss_pkg::REG_FIRST: prdata = {{(32-IW){1'b0}}, first_q};
      pss_pkg::REG_LAST:  prdata = {{(32-IW){1'b0}}, last_q};
      default:            prdata = '0;
    endcase
  end

  pss_coef_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (table_we),
    .waddr_i (term_index_i),
    .wdata_i (coeff_value_i),
    .raddr_i (idx_q),
    .rdata_o (coef)
  );

  // Terms below the range act as pure scaling steps by r
  assign slope_start = (first_q == '0) ? IW'(1) : first_q;
  assign idx_s       = $signed({1'b0, idx_q});
  assign sag_term    = (idx_q >= first_q) ? TW'(coef) : '0;
  assign slp_term    = (idx_q >= slope_start) ? TW'(coef) * TW'(idx_s) : '0;

  assign mac_a    = ph_q ? y_slp_q : y_sag_q;
  assign mac_term = ph_q ? slp_term : sag_term;

  pss_mac_unit u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .a_i    (mac_a),
    .b_i    (r_q),
    .term_i (mac_term),
    .rsp_o  (mac_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pss_pkg::ST_IDLE;
      ph_q    <= 1'b0;
      idx_q   <= '0;
      y_sag_q <= '0;
      y_slp_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      idx_q   <= idx_d;
      y_sag_q <= y_sag_d;
      y_slp_q <= y_slp_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  always_comb begin
    state_d       = state_q;
    ph_d          = ph_q;
    idx_d         = idx_q;
    r_d           = r_q;
    y_sag_d       = y_sag_q;
    y_slp_d       = y_slp_q;
    ov_d          = ov_q;
    mac_req.vld   = 1'b0;
    mac_req.chain = pss_pkg::CH_SAG;
    table_we      = 1'b0;
    out_load      = 1'b0;

    // Write back the product issued last cycle
    if (mac_rsp.vld) begin
      if (mac_rsp.chain == pss_pkg::CH_SAG) begin
        y_sag_d = mac_rsp.res;
      end else begin
        y_slp_d = mac_rsp.res;
      end
      ov_d = ov_q | mac_rsp.sat;
    end

    case (state_q)
      pss_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          y_sag_d = '0;
          y_slp_d = '0;
          ov_d    = 1'b0;
          if (func_i == pss_pkg::FUNC_WRITE) begin
            table_we = 1'b1;
            state_d  = pss_pkg::ST_DONE;
          end else begin
            r_d     = radius_i;
            idx_d   = last_q;
            ph_d    = 1'b0;
            state_d = pss_pkg::ST_RUN;
          end
        end
      end
      pss_pkg::ST_RUN: begin
        if (!ph_q) begin
          mac_req.vld   = 1'b1;
          mac_req.chain = pss_pkg::CH_SAG;
          ph_d          = 1'b1;
        end else if (idx_q != '0) begin
          mac_req.vld   = 1'b1;
          mac_req.chain = pss_pkg::CH_SLOPE;
          idx_d         = idx_q - IW'(1);
          ph_d          = 1'b0;
        end else begin
          // Power zero has no slope step; the sag product lands this cycle
          state_d = pss_pkg::ST_DONE;
        end
      end
      pss_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = pss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pss_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == pss_pkg::ST_IDLE);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sag_out_q <= y_sag_q;
      slp_out_q <= y_slp_q;
      ov_out_q  <= ov_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sag_value_o   = sag_out_q;
  assign slope_value_o = slp_out_q;
  assign overflow_o    = ov_out_q;

`ifndef SYNTHESIS
  a_wb_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_rsp.vld |-> (state_q == pss_pkg::ST_RUN))
    else $error("multiplier write-back outside of evaluation");

  a_write_goes_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (func_i == pss_pkg::FUNC_WRITE))
      |=> (state_q == pss_pkg::ST_DONE) && (y_sag_q == '0) && (y_slp_q == '0) && !ov_q)
    else $error("coefficient write did not yield a zero result");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pss_pkg::ST_RUN) && ph_q && (idx_q == '0)) |=> (state_q == pss_pkg::ST_DONE))
    else $error("evaluation did not finish after the last term");

  a_load_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");
`endif

endmodule

### hw/rtl/pss_coef_table.sv
// Coefficient register file, one write and one read port, cleared by reset.
module pss_coef_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic        [pss_pkg::IDX_W-1:0]   waddr_i,
  input  logic signed [pss_pkg::DATA_W-1:0]  wdata_i,
  input  logic        [pss_pkg::IDX_W-1:0]   raddr_i,
  output logic signed [pss_pkg::DATA_W-1:0]  rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [pss_pkg::DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        mem_q[i] <= '0;
      end
    end else if (we_i && (32'(waddr_i) < DEPTH)) begin
      mem_q[waddr_i[AW-1:0]] <= wdata_i;
    end
  end

  // Terms above the table read as zero
  assign rdata_o = (32'(raddr_i) < DEPTH) ? mem_q[raddr_i[AW-1:0]] : '0;

endmodule

### hw/rtl/pss_mac_unit.sv
// Shared multiply stage followed by round, add of the term and saturation.
module pss_mac_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pss_pkg::mac_req_t                  req_i,
  input  logic signed [pss_pkg::DATA_W-1:0]  a_i,
  input  logic signed [pss_pkg::DATA_W-1:0]  b_i,
  input  logic signed [pss_pkg::TERM_W-1:0]  term_i,
  output pss_pkg::mac_rsp_t                  rsp_o
);

  localparam int unsigned PW = pss_pkg::PROD_W;
  localparam int unsigned DW = pss_pkg::DATA_W;
  localparam logic signed [PW-1:0] BIAS = PW'(1) << (pss_pkg::FRAC_BITS - 1);

  logic                              vld_q;
  pss_pkg::chain_e                   chain_q;
  logic signed [PW-1:0]              prod_q;
  logic signed [pss_pkg::TERM_W-1:0] term_q;

  logic signed [PW-1:0] rounded;
  logic signed [PW-1:0] sum;
  logic                 ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      chain_q <= pss_pkg::CH_SAG;
    end else begin
      vld_q   <= req_i.vld;
      chain_q <= req_i.chain;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.vld) begin
      prod_q <= PW'(a_i) * PW'(b_i);
      term_q <= term_i;
    end
  end

  // Round half up: bias then floor shift
  assign rounded = (prod_q + BIAS) >>> pss_pkg::FRAC_BITS;
  assign sum     = rounded + PW'(term_q);
  assign ovf     = (sum[PW-1:DW-1] != '0) && (sum[PW-1:DW-1] != '1);

  always_comb begin
    rsp_o.vld   = vld_q;
    rsp_o.chain = chain_q;
    rsp_o.sat   = ovf;
    if (!ovf) begin
      rsp_o.res = sum[DW-1:0];
    end else if (sum[PW-1]) begin
      rsp_o.res = {1'b1, {(DW-1){1'b0}}};
    end else begin
      rsp_o.res = {1'b0, {(DW-1){1'b1}}};
    end
  end

endmodule

### dv/pss_sag_slope_checker.sv
// Checker: predicts sag, slope and overflow for every transfer and compares the results.
`timescale 1ns / 1ps
module pss_sag_slope_checker #(
  parameter int unsigned TERM_COUNT = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic        [pss_pkg::ADDR_W-1:0]   paddr,
  input  logic        [31:0]                  pwdata,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                func_i,
  input  logic        [pss_pkg::IDX_W-1:0]    term_index_i,
  input  logic signed [pss_pkg::DATA_W-1:0]   coeff_value_i,
  input  logic signed [pss_pkg::DATA_W-1:0]   radius_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [pss_pkg::DATA_W-1:0]   sag_value_i,
  input  logic signed [pss_pkg::DATA_W-1:0]   slope_value_i,
  input  logic                                overflow_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o,
  output int unsigned                         checked_o,
  output int unsigned                         saturated_o
);

  typedef struct packed {
    logic signed [pss_pkg::DATA_W-1:0] sag;
    logic signed [pss_pkg::DATA_W-1:0] slope;
    logic                              ovf;
  } sag_slope_t;

  localparam longint Q_MAX = (longint'(1) <<< 31) - 1;
  localparam longint Q_MIN = -(longint'(1) <<< 31);

  logic signed [pss_pkg::DATA_W-1:0] coef_tab [TERM_COUNT];
  logic        [pss_pkg::IDX_W-1:0]  range_lo;
  logic        [pss_pkg::IDX_W-1:0]  range_hi;
  sag_slope_t                        predicted_q [$];
  int unsigned                       fails;
  int unsigned                       checked;
  int unsigned                       saturated;

  // Rounded Q-format product: bias by half an LSB, then floor.
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b + (longint'(1) <<< (pss_pkg::FRAC_BITS - 1));
    return p >>> pss_pkg::FRAC_BITS;
  endfunction

  function automatic longint clamp32(input longint v, inout logic ovf);
    if (v > Q_MAX) begin
      ovf = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      ovf = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  function automatic sag_slope_t horner_sag_slope(
    input logic signed [pss_pkg::DATA_W-1:0] radius
  );
    sag_slope_t res;
    longint     r;
    longint     y;
    int         lo;
    int         hi;
    int         start;
    logic       ovf;
    r     = radius;
    lo    = int'(range_lo);
    hi    = int'(range_hi);
    start = (lo == 0) ? 1 : lo;
    ovf   = 1'b0;
    y     = 0;
    if (hi >= lo) begin
      for (int i = hi; i >= lo; i--) y = clamp32(fx_mul(y, r) + coef_tab[i], ovf);
      for (int i = 0; i < lo; i++) y = clamp32(fx_mul(y, r), ovf);
    end
    res.sag = y[pss_pkg::DATA_W-1:0];
    // power zero has no slope; scale by r^(start-1) so r = 0 stays defined
    y = 0;
    if (hi >= start) begin
      for (int i = hi; i >= start; i--) begin
        y = clamp32(fx_mul(y, r) + longint'(i) * coef_tab[i], ovf);
      end
      for (int i = 1; i < start; i++) y = clamp32(fx_mul(y, r), ovf);
    end
    res.slope = y[pss_pkg::DATA_W-1:0];
    res.ovf   = ovf;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sag_slope_t got;
    sag_slope_t want;
    if (!rst_ni) begin
      for (int k = 0; k < TERM_COUNT; k++) coef_tab[k] = '0;
      range_lo = '0;
      range_hi = '0;
      predicted_q.delete();
      fails     = 0;
      checked   = 0;
      saturated = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[2] == pss_pkg::REG_FIRST) range_lo = pwdata[pss_pkg::IDX_W-1:0];
        else range_hi = pwdata[pss_pkg::IDX_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        got.sag   = sag_value_i;
        got.slope = slope_value_i;
        got.ovf   = overflow_i;
        if (predicted_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: result with nothing outstanding: sag %h slope %h ovf %b",
                     $realtime, got.sag, got.slope, got.ovf);
          end
        end else begin
          want = predicted_q.pop_front();
          checked++;
          if (want.ovf) saturated++;
          if (got.sag !== want.sag || got.slope !== want.slope || got.ovf !== want.ovf) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch: sag exp %h got %h, slope exp %h got %h, ovf exp %b got %b",
                       $realtime, want.sag, got.sag, want.slope, got.slope, want.ovf, got.ovf);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (func_i == pss_pkg::FUNC_WRITE) begin
          if (term_index_i < TERM_COUNT) coef_tab[term_index_i] = coeff_value_i;
          want = '0;
        end else begin
          want = horner_sag_slope(radius_i);
        end
        predicted_q = {predicted_q, want};
      end
    end
    fail_count_o <= fails;
    pending_o    <= predicted_q.size();
    checked_o    <= checked;
    saturated_o  <= saturated;
  end

endmodule

### dv/polynomial_sag_and_slope_tb.sv
// Testbench top: drives coefficient writes, evaluations and range settings, gives the verdict.
`timescale 1ns / 1ps
module polynomial_sag_and_slope_tb;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned LONG_HOLD   = 400;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              psel          = 1'b0;
  logic                              penable       = 1'b0;
  logic                              pwrite        = 1'b0;
  logic        [pss_pkg::ADDR_W-1:0] paddr         = '0;
  logic        [31:0]                pwdata        = '0;
  logic        [31:0]                prdata;
  logic                              pready;
  logic                              in_valid_i    = 1'b0;
  logic                              in_ready_o;
  logic                              func_i        = pss_pkg::FUNC_WRITE;
  logic        [pss_pkg::IDX_W-1:0]  term_index_i  = '0;
  logic signed [pss_pkg::DATA_W-1:0] coeff_value_i = '0;
  logic signed [pss_pkg::DATA_W-1:0] radius_i      = '0;
  logic                              out_valid_o;
  logic                              out_ready_i   = 1'b0;
  logic signed [pss_pkg::DATA_W-1:0] sag_value_o;
  logic signed [pss_pkg::DATA_W-1:0] slope_value_o;
  logic                              overflow_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned saturated;
  int unsigned stuck_cycles = 0;
  int unsigned writes_sent  = 0;
  int unsigned evals_sent   = 0;
  int unsigned ranges_used  = 0;
  bit          calm_tx      = 1'b0;

  polynomial_sag_and_slope DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .term_index_i (term_index_i),
    .coeff_value_i(coeff_value_i),
    .radius_i     (radius_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sag_value_o  (sag_value_o),
    .slope_value_o(slope_value_o),
    .overflow_o   (overflow_o)
  );

  pss_sag_slope_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .func_i       (func_i),
    .term_index_i (term_index_i),
    .coeff_value_i(coeff_value_i),
    .radius_i     (radius_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sag_value_i  (sag_value_o),
    .slope_value_i(slope_value_o),
    .overflow_i   (overflow_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .saturated_o  (saturated)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly no gap, some short ones, a few long; none at all when calm.
  function automatic int unsigned idle_len(input bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0100_0000;
          3:       return 32'hFF00_0000;
          default: return 32'h0000_0000;
        endcase
      end
      1, 2:    return $urandom();
      3, 4:    return $urandom_range(0, 32'h0000_01FF) - 32'h0000_0100;
      default: return $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000;
    endcase
  endfunction

  // Radius mostly within +/-1.25 so long polynomials do not always saturate.
  function automatic logic [31:0] pick_radius();
    case ($urandom_range(0, 19))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3, 4:    return $urandom();
      default: return $urandom_range(0, 32'h027F_FFFF) - 32'h0140_0000;
    endcase
  endfunction

  task automatic send(input logic fn, input logic [pss_pkg::IDX_W-1:0] idx,
                      input logic [31:0] coeff, input logic [31:0] rad);
    int unsigned gap;
    gap = idle_len(calm_tx);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    term_index_i  <= idx;
    coeff_value_i <= coeff;
    radius_i      <= rad;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic push_write(input int unsigned idx, input logic [31:0] coeff);
    send(pss_pkg::FUNC_WRITE, idx[pss_pkg::IDX_W-1:0], coeff, $urandom());
    writes_sent++;
  endtask

  task automatic push_eval(input logic [31:0] rad);
    send(pss_pkg::FUNC_EVAL, pss_pkg::IDX_W'($urandom_range(0, 15)), $urandom(), rad);
    evals_sent++;
  endtask

  // Hold the input until every outstanding result has been checked.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic sel, input logic [pss_pkg::IDX_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {28'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_range(input logic [pss_pkg::IDX_W-1:0] lo,
                           input logic [pss_pkg::IDX_W-1:0] hi);
    drain();
    write_reg(pss_pkg::REG_FIRST, lo);
    write_reg(pss_pkg::REG_LAST, hi);
    ranges_used++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding", stuck_cycles, pending);
      $display("polynomial_sag_and_slope test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : receiver
    int unsigned gap;
    bit          held;
    gap  = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      // one long back-pressure stretch so the block fills and stalls its input
      if (!held && checked >= 300) begin
        held = 1'b1;
        gap  = LONG_HOLD;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        gap--;
      end else begin
        out_ready_i <= 1'b1;
        gap = idle_len((checked / 120) % 3 == 1);
      end
    end
  end

  initial begin : stimulus
    logic [pss_pkg::IDX_W-1:0] lo;
    logic [pss_pkg::IDX_W-1:0] hi;
    int unsigned               phase_items;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset range is first = last = 0: sag is c0 alone, slope has no terms
    push_eval(32'h0000_0000);
    push_write(0, 32'h7FFF_FFFF);
    push_eval(32'h8000_0000);
    set_range(4'd0, 4'd15);
    push_write(15, 32'h8000_0000);
    push_write(1, 32'h0100_0000);
    push_write(7, 32'hFF00_0000);
    push_eval(32'h0000_0000);
    push_eval(32'h0100_0000);
    push_eval(32'hFF00_0000);
    push_eval(32'h7FFF_FFFF);
    push_eval(32'h0000_0001);
    // empty range: last below first
    set_range(4'd9, 4'd4);
    push_eval(32'h0100_0000);
    set_range(4'd15, 4'd15);
    push_eval(32'h0080_0000);
    push_write(15, 32'h0000_0000);
    push_eval(32'h8000_0000);
    // lone linear term at r = 0: slope is c1 unscaled
    set_range(4'd1, 4'd1);
    push_eval(32'h0000_0000);
    set_range(4'd3, 4'd7);
    push_write(3, 32'hFFFF_FFFF);
    push_eval(32'h0000_0000);
    push_eval(32'hFFFF_FFFF);

    for (int p = 0; p < 10; p++) begin
      case (p % 5)
        0: begin
          lo = 4'd0;
          hi = 4'd15;
        end
        1: begin
          lo = 4'd15;
          hi = 4'd15;
        end
        2: begin
          lo = 4'd0;
          hi = 4'd0;
        end
        3: begin
          lo = pss_pkg::IDX_W'($urandom_range(0, 15));
          hi = pss_pkg::IDX_W'($urandom_range(0, 15));
        end
        default: begin
          lo = pss_pkg::IDX_W'($urandom_range(0, 4));
          hi = lo + pss_pkg::IDX_W'($urandom_range(0, 6));
        end
      endcase
      set_range(lo, hi);
      calm_tx     = (p % 3 == 2);
      phase_items = 0;
      // load the active terms, then mostly evaluate with a few rewrites
      for (int t = lo; t <= hi; t++) begin
        push_write(t, pick_coeff());
        phase_items++;
      end
      while (phase_items < 93) begin
        if ($urandom_range(0, 99) < 72) push_eval(pick_radius());
        else push_write($urandom_range(0, 15), pick_coeff());
        phase_items++;
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("covered %0d coefficient writes and %0d evaluations over %0d term ranges",
             writes_sent, evals_sent, ranges_used);
    $display("%0d results checked, %0d with saturation, %0d failures",
             checked, saturated, fail_count);
    if (fail_count == 0) begin
      $display("polynomial_sag_and_slope test passed");
    end else begin
      $display("polynomial_sag_and_slope test failed");
    end
    $finish;
  end

endmodule
